@@ rtl/fragment_reassembly_command_handler_defines.svh @@
// Assertion macros shared by the front, job queue and back end RTL files.
`ifndef FRAGMENT_REASSEMBLY_COMMAND_HANDLER_DEFINES_SVH
`define FRAGMENT_REASSEMBLY_COMMAND_HANDLER_DEFINES_SVH

`ifndef SYNTHESIS
`define FRCH_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("frch assertion failed");
`define FRCH_NEVER(label, clk, rst_n, cond) \
    `FRCH_ASSERT(label, clk, rst_n, !(cond))
`else
`define FRCH_ASSERT(label, clk, rst_n, prop)
`define FRCH_NEVER(label, clk, rst_n, cond)
`endif

`endif

@@ rtl/frch_pkg.sv @@
package frch_pkg;

    typedef enum logic [1:0] {
        PH_READY     = 2'd0,
        PH_RECEIVING = 2'd1,
        PH_RECEIVED  = 2'd2
    } phase_t;

    typedef logic [1:0] func_t;
    localparam func_t FN_BYTE    = 2'd0;
    localparam func_t FN_EMPTY   = 2'd1;
    localparam func_t FN_RELEASE = 2'd2;
    localparam func_t FN_READ    = 2'd3;

    localparam logic [7:0] OP_QUERY      = 8'h03;
    localparam logic [7:0] OP_RESET      = 8'h02;
    localparam logic [7:0] OP_START      = 8'h06;
    localparam logic [7:0] OP_CONTINUE   = 8'h07;
    localparam logic [7:0] QUERY_VERSION = 8'h01;

    typedef logic [2:0] status_t;
    localparam status_t ST_OK      = 3'd0;
    localparam status_t ST_BUSY    = 3'd1;
    localparam status_t ST_BAD     = 3'd2;
    localparam status_t ST_OVERRUN = 3'd3;
    localparam status_t ST_MISSING = 3'd4;

    typedef logic [1:0] kind_t;
    localparam kind_t KIND_RESP  = 2'd0;
    localparam kind_t KIND_EVENT = 2'd1;
    localparam kind_t KIND_READ  = 2'd2;

    localparam logic CFG_MODEL  = 1'b0;
    localparam logic CFG_SERIAL = 1'b1;

    typedef enum logic [1:0] {
        JOB_READ,
        JOB_EMPTY,
        JOB_QUERY,
        JOB_RESP
    } job_kind_t;

    // One classified request handed from front to back
    typedef struct packed {
        job_kind_t   kind;
        logic [7:0]  data;       // command byte, or store byte for a read
        status_t     status;
        logic        evt_flag;   // completion event precedes the response
        logic [15:0] len_a;      // event length, or fill offset for a query
        logic [15:0] len_b;      // expected length for a query
    } job_t;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int QCW    = 3;

    function automatic logic [7:0] status_byte(input status_t st);
        logic [7:0] b;
        unique case (st)
            ST_OK:      b = 8'h00;
            ST_BUSY:    b = 8'h91;
            ST_BAD:     b = 8'h82;
            ST_OVERRUN: b = 8'h84;
            ST_MISSING: b = 8'h85;
            default:    b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

@@ rtl/frch_front.sv @@
`include "fragment_reassembly_command_handler_defines.svh"

module frch_front #(
    parameter int STORE_BYTES = 2048
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [1:0]                  func,
    input  logic [7:0]                  req_byte,
    input  logic                        req_last,
    input  logic [15:0]                 read_address,
    input  logic [frch_pkg::QCW-1:0]    q_count,
    output logic                        job_valid,
    output frch_pkg::job_t              job
);
    import frch_pkg::*;

    localparam int AW = $clog2(STORE_BYTES);

    logic [7:0] mem [STORE_BYTES];

    phase_t      phase_reg, phase_next;
    logic [15:0] fill_reg, fill_next;
    logic [15:0] exp_reg, exp_next;
    logic [7:0]  cmd_reg, cmd_next;
    logic [15:0] hdr_reg, hdr_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        hacc_reg, hacc_next;

    logic        s1_valid_reg;
    job_t        s1_job_reg;
    logic        rd_oob_reg;
    logic [7:0]  rd_data_reg;

    logic        acc;
    logic        cnt_inc;
    logic [7:0]  cmd_new;
    logic [15:0] hdr_new;
    logic        pay_ok;
    logic        hacc_new;
    logic [16:0] widx;
    logic        we;
    logic        rd_en;
    logic [15:0] len;
    logic [15:0] pay_len;
    status_t     st;
    logic [15:0] fill_upd;
    logic [15:0] exp_upd;
    logic        evt;
    logic        job_gen;
    job_t        job_c;

    assign full  = ({1'b0, q_count} + {{QCW{1'b0}}, s1_valid_reg}) >= (QCW+1)'(QDEPTH);
    assign acc   = push && !full;
    assign rd_en = acc && (func == FN_READ);

    // request assembly and judgement
    always_comb
    begin
        cnt_inc  = (cnt_reg != 16'hFFFF);
        cmd_new  = (cnt_inc && cnt_reg == 16'd0) ? req_byte : cmd_reg;
        hdr_new  = hdr_reg;
        if (cnt_inc && cnt_reg == 16'd1)
        begin
            hdr_new = {req_byte, 8'h00};
        end
        else if (cnt_inc && cnt_reg == 16'd2)
        begin
            hdr_new = {hdr_reg[15:8], req_byte};
        end

        if (cmd_reg == OP_START)
        begin
            pay_ok = (phase_reg == PH_READY) && (hdr_reg != 16'd0) && (fill_reg == 16'd0);
        end
        else if (cmd_reg == OP_CONTINUE)
        begin
            pay_ok = (phase_reg == PH_RECEIVING) && (fill_reg != 16'd0)
                     && (hdr_reg == fill_reg);
        end
        else
        begin
            pay_ok = 1'b0;
        end
        hacc_new = (cnt_inc && cnt_reg == 16'd3) ? pay_ok : hacc_reg;

        widx = {1'b0, (cmd_reg == OP_START) ? 16'd0 : hdr_reg} + {1'b0, cnt_reg - 16'd3};
        we   = acc && (func == FN_BYTE) && cnt_inc && (cnt_reg >= 16'd3) && hacc_new
               && (widx < 17'(STORE_BYTES));

        len     = cnt_inc ? cnt_reg + 16'd1 : cnt_reg;
        pay_len = len - 16'd3;

        unique case (cmd_new)
            OP_RESET:
            begin
                st = (phase_reg == PH_READY || phase_reg == PH_RECEIVING) ? ST_OK : ST_BUSY;
            end
            OP_START:
            begin
                if (phase_reg != PH_READY)
                    st = ST_BUSY;
                else if (len < 16'd3)
                    st = ST_OVERRUN;
                else if (hdr_new == 16'd0 || len < 16'd4 || fill_reg != 16'd0)
                    st = ST_MISSING;
                else
                    st = ST_OK;
            end
            OP_CONTINUE:
            begin
                if (phase_reg != PH_RECEIVING)
                    st = ST_BUSY;
                else if (len < 16'd3)
                    st = ST_OVERRUN;
                else if (fill_reg == 16'd0 || len < 16'd4 || hdr_new != fill_reg)
                    st = ST_MISSING;
                else
                    st = ST_OK;
            end
            default:
            begin
                st = ST_BAD;
            end
        endcase

        fill_upd = (cmd_new == OP_START) ? pay_len : fill_reg + pay_len;
        exp_upd  = (cmd_new == OP_START) ? hdr_new : exp_reg;
        evt      = (st == ST_OK) && (cmd_new != OP_RESET) && (fill_upd == exp_upd);
    end

    // request registers, fill offset and expected length
    always_comb
    begin
        cmd_next  = cmd_reg;
        hdr_next  = hdr_reg;
        cnt_next  = cnt_reg;
        hacc_next = hacc_reg;
        fill_next = fill_reg;
        exp_next  = exp_reg;
        if (acc)
        begin
            case (func)
                FN_BYTE:
                begin
                    if (req_last)
                    begin
                        cmd_next  = 8'd0;
                        hdr_next  = 16'd0;
                        cnt_next  = 16'd0;
                        hacc_next = 1'b0;
                        if (cmd_new != OP_QUERY && st == ST_OK)
                        begin
                            fill_next = (cmd_new == OP_RESET) ? 16'd0 : fill_upd;
                            exp_next  = (cmd_new == OP_RESET) ? 16'd0 : exp_upd;
                        end
                    end
                    else
                    begin
                        cmd_next  = cmd_new;
                        hdr_next  = hdr_new;
                        cnt_next  = len;
                        hacc_next = hacc_new;
                    end
                end
                FN_EMPTY:
                begin
                    cmd_next  = 8'd0;
                    hdr_next  = 16'd0;
                    cnt_next  = 16'd0;
                    hacc_next = 1'b0;
                end
                FN_RELEASE:
                begin
                    cmd_next  = 8'd0;
                    hdr_next  = 16'd0;
                    cnt_next  = 16'd0;
                    hacc_next = 1'b0;
                    fill_next = 16'd0;
                    exp_next  = 16'd0;
                end
                default:
                begin
                end
            endcase
        end
    end

    // phase next state
    always_comb
    begin
        phase_next = phase_reg;
        if (acc && func == FN_RELEASE)
        begin
            phase_next = PH_READY;
        end
        else if (acc && func == FN_BYTE && req_last && cmd_new != OP_QUERY && st == ST_OK)
        begin
            if (cmd_new == OP_RESET)
                phase_next = PH_READY;
            else if (evt)
                phase_next = PH_RECEIVED;
            else if (cmd_new == OP_START)
                phase_next = PH_RECEIVING;
        end
    end

    // classify into a job for the back end
    always_comb
    begin
        job_c          = '0;
        job_gen        = 1'b0;
        job_c.data     = cmd_new;
        job_c.status   = st;
        job_c.evt_flag = evt;
        job_c.len_a    = exp_upd;
        job_c.len_b    = exp_reg;
        job_c.kind     = JOB_RESP;
        if (acc)
        begin
            case (func)
                FN_BYTE:
                begin
                    job_gen = req_last;
                    if (cmd_new == OP_QUERY)
                    begin
                        job_c.kind     = JOB_QUERY;
                        job_c.status   = ST_OK;
                        job_c.evt_flag = 1'b0;
                        job_c.len_a    = fill_reg;
                    end
                end
                FN_EMPTY:
                begin
                    job_gen      = 1'b1;
                    job_c.kind   = JOB_EMPTY;
                    job_c.status = ST_OVERRUN;
                end
                FN_READ:
                begin
                    job_gen    = 1'b1;
                    job_c.kind = JOB_READ;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_READY;
            fill_reg     <= 16'd0;
            exp_reg      <= 16'd0;
            cmd_reg      <= 8'd0;
            hdr_reg      <= 16'd0;
            cnt_reg      <= 16'd0;
            hacc_reg     <= 1'b0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            fill_reg     <= fill_next;
            exp_reg      <= exp_next;
            cmd_reg      <= cmd_next;
            hdr_reg      <= hdr_next;
            cnt_reg      <= cnt_next;
            hacc_reg     <= hacc_next;
            s1_valid_reg <= job_gen;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_gen)
        begin
            s1_job_reg <= job_c;
        end
        if (rd_en)
        begin
            rd_oob_reg <= ({1'b0, read_address} >= 17'(STORE_BYTES));
        end
    end

    // message store
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[widx[AW-1:0]] <= req_byte;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[read_address[AW-1:0]];
        end
    end

    always_comb
    begin
        job = s1_job_reg;
        if (s1_job_reg.kind == JOB_READ)
        begin
            job.data = rd_oob_reg ? 8'd0 : rd_data_reg;
        end
    end

    assign job_valid = s1_valid_reg;

    `FRCH_ASSERT(a_ready_clean, clk, rst_n, (phase_reg == PH_READY) |-> (fill_reg == 16'd0 && exp_reg == 16'd0))

endmodule

@@ rtl/frch_jobq.sv @@
`include "fragment_reassembly_command_handler_defines.svh"

module frch_jobq (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  frch_pkg::job_t              din,
    input  logic                        pop,
    output logic                        valid,
    output frch_pkg::job_t              dout,
    output logic [frch_pkg::QCW-1:0]    count
);
    import frch_pkg::*;

    job_t             q_mem [QDEPTH];
    logic [QAW-1:0]   head_reg, head_next;
    logic [QAW-1:0]   tail_reg, tail_next;
    logic [QCW-1:0]   count_reg, count_next;

    always_comb
    begin
        head_next  = pop  ? head_reg + QAW'(1) : head_reg;
        tail_next  = push ? tail_reg + QAW'(1) : tail_reg;
        count_next = count_reg + QCW'(push) - QCW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[tail_reg] <= din;
        end
    end

    assign dout  = q_mem[head_reg];
    assign valid = (count_reg != '0);
    assign count = count_reg;

    `FRCH_NEVER(a_q_overflow, clk, rst_n, push && !pop && (count_reg == QCW'(QDEPTH)))
    `FRCH_NEVER(a_q_underflow, clk, rst_n, pop && (count_reg == '0))

endmodule

@@ rtl/frch_back.sv @@
`include "fragment_reassembly_command_handler_defines.svh"

module frch_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              job_valid,
    input  frch_pkg::job_t    job,
    output logic              job_pop,
    input  logic [31:0]       model_number,
    input  logic [31:0]       serial_number,
    input  logic              pop,
    output logic              empty,
    output logic [1:0]        out_kind,
    output logic [7:0]        out_byte,
    output logic              out_last,
    output logic [15:0]       message_length,
    output logic [2:0]        status_code
);
    import frch_pkg::*;

    logic [3:0]  step_reg, step_next;
    logic        out_valid_reg, out_valid_next;
    kind_t       out_kind_reg;
    logic [7:0]  out_byte_reg;
    logic        out_last_reg;
    logic [15:0] out_len_reg;
    status_t     out_st_reg;

    logic [4:0]  nres;
    logic        last_step;
    logic        load;
    logic [1:0]  rstep;
    logic [7:0]  qbyte;
    kind_t       r_kind;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [15:0] r_len;
    status_t     r_st;

    always_comb
    begin
        case (job.kind)
            JOB_QUERY: nres = 5'd16;
            JOB_RESP:  nres = job.evt_flag ? 5'd3 : 5'd2;
            default:   nres = 5'd1;
        endcase
        last_step = ({1'b0, step_reg} == nres - 5'd1);
        load      = job_valid && (!out_valid_reg || pop);
        job_pop   = load && last_step;
    end

    // query report byte for the current step
    always_comb
    begin
        unique case (step_reg)
            4'd0:    qbyte = status_byte(ST_OK);
            4'd1:    qbyte = job.data;
            4'd2:    qbyte = OP_QUERY;
            4'd3:    qbyte = QUERY_VERSION;
            4'd4:    qbyte = job.len_a[15:8];
            4'd5:    qbyte = job.len_a[7:0];
            4'd6:    qbyte = job.len_b[15:8];
            4'd7:    qbyte = job.len_b[7:0];
            4'd8:    qbyte = model_number[31:24];
            4'd9:    qbyte = model_number[23:16];
            4'd10:   qbyte = model_number[15:8];
            4'd11:   qbyte = model_number[7:0];
            4'd12:   qbyte = serial_number[31:24];
            4'd13:   qbyte = serial_number[23:16];
            4'd14:   qbyte = serial_number[15:8];
            4'd15:   qbyte = serial_number[7:0];
            default: qbyte = 8'h00;
        endcase
    end

    // expand the job into its result for this step
    always_comb
    begin
        rstep  = job.evt_flag ? step_reg[1:0] : step_reg[1:0] + 2'd1;
        r_kind = KIND_RESP;
        r_byte = 8'h00;
        r_last = 1'b0;
        r_len  = 16'd0;
        r_st   = ST_OK;
        case (job.kind)
            JOB_READ:
            begin
                r_kind = KIND_READ;
                r_byte = job.data;
            end
            JOB_EMPTY:
            begin
                r_byte = status_byte(ST_OVERRUN);
                r_last = 1'b1;
                r_st   = ST_OVERRUN;
            end
            JOB_QUERY:
            begin
                r_byte = qbyte;
                r_last = (step_reg == 4'd15);
            end
            default:
            begin
                if (rstep == 2'd0)
                begin
                    r_kind = KIND_EVENT;
                    r_len  = job.len_a;
                end
                else if (rstep == 2'd1)
                begin
                    r_byte = status_byte(job.status);
                    r_st   = job.status;
                end
                else
                begin
                    r_byte = job.data;
                    r_last = 1'b1;
                    r_st   = job.status;
                end
            end
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            step_next      = last_step ? 4'd0 : step_reg + 4'd1;
            out_valid_next = 1'b1;
        end
        else if (pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg <= r_kind;
            out_byte_reg <= r_byte;
            out_last_reg <= r_last;
            out_len_reg  <= r_len;
            out_st_reg   <= r_st;
        end
    end

    assign empty          = !out_valid_reg;
    assign out_kind       = out_kind_reg;
    assign out_byte       = out_byte_reg;
    assign out_last       = out_last_reg;
    assign message_length = out_len_reg;
    assign status_code    = out_st_reg;

    `FRCH_ASSERT(a_step_bound, clk, rst_n, job_valid |-> ({1'b0, step_reg} < nres))

endmodule

@@ rtl/fragment_reassembly_command_handler.sv @@
// Command handler that rebuilds a fragmented message from byte-wide requests.
// Input channel (push/full): one transaction per byte; func selects request byte,
// empty request, release to ready or store read. req_last closes a request.
// Result channel (empty/pop): response bytes, completion events and store read
// data, oldest first, one transaction per cycle while pop is held.
// Config port (cfg_we/cfg_index/cfg_data): index 0 model number, 1 serial number;
// write only while the block is idle.
// An item's first result passes the front stage register and the job queue
// before the output register. A query yields 16 results, other requests up to 3.
// Throughput: one input item per cycle while full is low; the back end drains
// one result per cycle while pop is held, and a four-deep job queue between front
// and back sets how many multi-result requests can be absorbed before full rises.
// Reset: phase ready, offsets cleared, queues empty. The message store is not
// cleared; there is no clearing pass. When pop is held low, results hold in
// the output register, the job queue fills and full stalls the input.
module fragment_reassembly_command_handler #(
    parameter int STORE_BYTES = 2048
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    output logic         full,
    input  logic [1:0]   func,
    input  logic [7:0]   req_byte,
    input  logic         req_last,
    input  logic [15:0]  read_address,
    output logic         empty,
    input  logic         pop,
    output logic [1:0]   out_kind,
    output logic [7:0]   out_byte,
    output logic         out_last,
    output logic [15:0]  message_length,
    output logic [2:0]   status_code,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_data
);
    import frch_pkg::*;

    logic [31:0]     model_reg;
    logic [31:0]     serial_reg;

    // front to queue
    logic            f_job_valid;
    job_t            f_job;
    // queue to back
    logic            q_valid;
    job_t            q_job;
    logic            q_pop;
    logic [QCW-1:0]  q_count;

    // configuration registers: take the write straight away
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_reg  <= 32'd0;
            serial_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MODEL:  model_reg  <= cfg_data;
                CFG_SERIAL: serial_reg <= cfg_data;
                default:    model_reg  <= model_reg;
            endcase
        end
    end

    // front: assemble requests, judge them, write the store
    frch_front #(
        .STORE_BYTES (STORE_BYTES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .func         (func),
        .req_byte     (req_byte),
        .req_last     (req_last),
        .read_address (read_address),
        .q_count      (q_count),
        .job_valid    (f_job_valid),
        .job          (f_job)
    );

    // hold classified jobs so front and back stall independently
    frch_jobq u_jobq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_job_valid),
        .din   (f_job),
        .pop   (q_pop),
        .valid (q_valid),
        .dout  (q_job),
        .count (q_count)
    );

    // back: expand each job into result transactions
    frch_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (q_valid),
        .job            (q_job),
        .job_pop        (q_pop),
        .model_number   (model_reg),
        .serial_number  (serial_reg),
        .pop            (pop),
        .empty          (empty),
        .out_kind       (out_kind),
        .out_byte       (out_byte),
        .out_last       (out_last),
        .message_length (message_length),
        .status_code    (status_code)
    );

endmodule
